// ----- rtl/assert_macros.svh -----
// assertion helpers for the timer queue checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside of reset
`define DLTQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("timer queue check failed");

// property checked on every edge, reset included
`define DLTQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("timer queue check failed");

`endif

// ----- rtl/dltq_pkg.sv -----
package dltq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 16;

    localparam int DELTA_W   = 31;
    localparam int DELAY_W   = 32;
    localparam int TPS_W     = 20;
    localparam int OKEY_W    = 16;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int PROD_W    = DELTA_W + TPS_W;

    localparam logic [DELTA_W-1:0] MAX_DELTA = {DELTA_W{1'b1}};
    localparam logic [TPS_W-1:0]   TPS_RESET = TPS_W'(1000);

    // most expirations one tick may report
    localparam int MAX_RESULTS = 16;

    // command queue between front and back, power of two
    localparam int Q_DEPTH = 2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // register index as seen on paddr[2]
    localparam logic REG_TPS = 1'b0;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_FULL    = 2'd1,
        KIND_EXPIRED = 2'd2
    } t_kind;

    typedef struct packed {
        logic               func;
        logic [DELTA_W-1:0] ticks;
        logic [OKEY_W-1:0]  key;
    } t_cmd;

endpackage

// ----- rtl/dltq_front.sv -----
module dltq_front #(
    parameter int KEY_BITS = dltq_pkg::KEY_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_func,
    input  logic [dltq_pkg::DELAY_W-1:0] i_delay_seconds,
    input  logic [dltq_pkg::OKEY_W-1:0]  i_entry_key,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dltq_pkg::PADDR_W-1:0] paddr,
    input  logic [dltq_pkg::PDATA_W-1:0] pwdata,
    output logic [dltq_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output logic                         o_push,
    output dltq_pkg::t_cmd               o_cmd,
    input  logic                         i_q_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_SAT  = 3'b100
    } t_fstate;

    localparam logic [63:0] KEY_MASK = (64'd1 << KEY_BITS) - 64'd1;

    t_fstate r_state, n_state;
    logic [dltq_pkg::TPS_W-1:0]   r_tps;
    logic                         r_func;
    logic [dltq_pkg::DELAY_W-1:0] r_delay;
    logic [dltq_pkg::OKEY_W-1:0]  r_key;
    logic [dltq_pkg::PROD_W-1:0]  r_prod;
    logic [dltq_pkg::PROD_W-1:0]  prod_c;
    logic [63:0]                  key_ext;
    logic [dltq_pkg::DELTA_W-1:0] ticks_c;
    logic                         accept;
    logic                         cfg_wr;

    assign accept     = i_in_valid && (r_state == F_IDLE);
    assign o_in_stall = (r_state != F_IDLE);
    assign cfg_wr     = psel && penable && pwrite && (paddr[2] == dltq_pkg::REG_TPS);
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == dltq_pkg::REG_TPS) ?
                        dltq_pkg::PDATA_W'(r_tps) : '0;

    assign key_ext = 64'(i_entry_key) & KEY_MASK;
    assign prod_c  = r_delay[dltq_pkg::DELTA_W-1:0] * r_tps;

    // negative delay means never, and a product beyond the largest delta saturates: both give the largest delta
    always_comb begin
        if (r_delay[dltq_pkg::DELAY_W-1] ||
            (r_prod > dltq_pkg::PROD_W'(dltq_pkg::MAX_DELTA))) begin
            ticks_c = dltq_pkg::MAX_DELTA;
        end else begin
            ticks_c = r_prod[dltq_pkg::DELTA_W-1:0];
        end
    end

    assign o_push      = (r_state == F_SAT) && !i_q_full;
    assign o_cmd.func  = r_func;
    assign o_cmd.ticks = ticks_c;
    assign o_cmd.key   = r_key;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept) n_state = F_MUL;
            end
            F_MUL:  n_state = F_SAT;
            F_SAT: begin
                if (!i_q_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_tps   <= dltq_pkg::TPS_RESET;
        end else begin
            r_state <= n_state;
            if (cfg_wr) r_tps <= pwdata[dltq_pkg::TPS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_delay <= i_delay_seconds;
            r_key   <= key_ext[dltq_pkg::OKEY_W-1:0];
        end
        if (r_state == F_MUL) r_prod <= prod_c;
    end

endmodule

// ----- rtl/dltq_cmd_queue.sv -----
module dltq_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dltq_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output dltq_pkg::t_cmd o_cmd
);

    localparam int QAW = (dltq_pkg::Q_DEPTH > 1) ? $clog2(dltq_pkg::Q_DEPTH) : 1;
    localparam int QCW = $clog2(dltq_pkg::Q_DEPTH + 1);

    dltq_pkg::t_cmd r_slot [dltq_pkg::Q_DEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == QCW'(dltq_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_slot[r_rp];

    // pointers wrap on their own since the depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + QCW'(do_push) - QCW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wp] <= i_cmd;
    end

endmodule

// ----- rtl/dltq_back.sv -----
module dltq_back #(
    parameter int DEPTH    = dltq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = dltq_pkg::KEY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  dltq_pkg::t_cmd              i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_out_kind,
    output logic [dltq_pkg::OKEY_W-1:0] o_out_key,
    output logic                        o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = $clog2(dltq_pkg::MAX_RESULTS + 1);
    localparam int DW = dltq_pkg::DELTA_W;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_INS_RUN = 6'b000010,
        ST_INS_END = 6'b000100,
        ST_TICK_RD = 6'b001000,
        ST_TICK_NX = 6'b010000,
        ST_EMIT    = 6'b100000
    } t_bstate;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // list storage, oldest expiration at r_head
    logic [DW-1:0]       r_mem_delta [DEPTH];
    logic [KEY_BITS-1:0] r_mem_key   [DEPTH];
    logic [DW-1:0]       r_rd_delta;
    logic [KEY_BITS-1:0] r_rd_key;

    t_bstate r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_idx, n_idx;
    logic [NW-1:0]       r_nres, n_nres;
    logic [DW-1:0]       r_rem, n_rem;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic                r_walk, n_walk;
    logic [DW-1:0]       r_cd, n_cd;
    logic [KEY_BITS-1:0] r_ck, n_ck;
    dltq_pkg::t_kind     r_res_kind, n_res_kind;
    logic [KEY_BITS-1:0] r_res_key, n_res_key;

    logic                        r_out_valid, n_out_valid;
    logic [1:0]                  r_out_kind, n_out_kind;
    logic [dltq_pkg::OKEY_W-1:0] r_out_key, n_out_key;
    logic                        r_out_last, n_out_last;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [DW-1:0]       wdelta;
    logic [KEY_BITS-1:0] wkey;
    logic [AW-1:0]       rd_addr;
    logic                out_free;
    logic [63:0]         cmd_key_ext;
    logic [63:0]         res_key_ext;

    assign cmd_key_ext = 64'(i_q_cmd.key);
    assign res_key_ext = 64'(r_res_key);
    assign out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_key   = r_out_key;
    assign o_last      = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_nres      = r_nres;
        n_rem       = r_rem;
        n_key       = r_key;
        n_walk      = r_walk;
        n_cd        = r_cd;
        n_ck        = r_ck;
        n_res_kind  = r_res_kind;
        n_res_key   = r_res_key;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_kind  = r_out_kind;
        n_out_key   = r_out_key;
        n_out_last  = r_out_last;
        we          = 1'b0;
        waddr       = r_ptr;
        wdelta      = r_cd;
        wkey        = r_ck;
        rd_addr     = r_head;
        o_q_pop     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop   = 1'b1;
                    n_key     = cmd_key_ext[KEY_BITS-1:0];
                    n_rem     = i_q_cmd.ticks;
                    n_res_key = cmd_key_ext[KEY_BITS-1:0];
                    if (i_q_cmd.func == dltq_pkg::FUNC_INSERT) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res_kind = dltq_pkg::KIND_FULL;
                            n_state    = ST_EMIT;
                        end else begin
                            n_res_kind = dltq_pkg::KIND_ACK;
                            n_walk     = 1'b1;
                            n_ptr      = r_head;
                            n_idx      = '0;
                            n_state    = (r_count == '0) ? ST_INS_END : ST_INS_RUN;
                        end
                    end else if (r_count != '0) begin
                        n_res_kind = dltq_pkg::KIND_EXPIRED;
                        n_state    = ST_TICK_RD;
                    end
                end
            end
            ST_INS_RUN: begin
                // one stored entry per cycle, reads run one slot ahead
                rd_addr = ptr_inc(r_ptr);
                we      = 1'b1;
                if (r_walk) begin
                    if (r_rd_delta < r_rem) begin
                        we    = 1'b0;
                        n_rem = r_rem - r_rd_delta;
                    end else begin
                        wdelta = r_rem;
                        wkey   = r_key;
                        n_cd   = r_rd_delta - r_rem;
                        n_ck   = r_rd_key;
                        n_walk = 1'b0;
                    end
                end else begin
                    n_cd = r_rd_delta;
                    n_ck = r_rd_key;
                end
                n_ptr = ptr_inc(r_ptr);
                n_idx = r_idx + 1'b1;
                if (r_idx == (r_count - CW'(1))) n_state = ST_INS_END;
            end
            ST_INS_END: begin
                we      = 1'b1;
                wdelta  = r_walk ? r_rem : r_cd;
                wkey    = r_walk ? r_key : r_ck;
                n_count = r_count + 1'b1;
                n_state = ST_EMIT;
            end
            ST_TICK_RD: begin
                if (r_rd_delta > DW'(1)) begin
                    we      = 1'b1;
                    waddr   = r_head;
                    wdelta  = r_rd_delta - DW'(1);
                    wkey    = r_rd_key;
                    n_state = ST_IDLE;
                end else begin
                    n_res_key = r_rd_key;
                    n_head    = ptr_inc(r_head);
                    n_count   = r_count - CW'(1);
                    n_nres    = NW'(1);
                    rd_addr   = n_head;
                    if ((n_count != '0) && (n_nres < NW'(dltq_pkg::MAX_RESULTS))) begin
                        n_state = ST_TICK_NX;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_TICK_NX: begin
                // pending key goes out once the next front entry is known
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_key   = res_key_ext[dltq_pkg::OKEY_W-1:0];
                    if (r_rd_delta == '0) begin
                        n_out_last = 1'b0;
                        n_res_key  = r_rd_key;
                        n_head     = ptr_inc(r_head);
                        n_count    = r_count - CW'(1);
                        n_nres     = r_nres + 1'b1;
                        rd_addr    = n_head;
                        if (!((n_count != '0) && (n_nres < NW'(dltq_pkg::MAX_RESULTS)))) begin
                            n_state = ST_EMIT;
                        end
                    end else begin
                        n_out_last = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_key   = res_key_ext[dltq_pkg::OKEY_W-1:0];
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_idx      <= n_idx;
        r_nres     <= n_nres;
        r_rem      <= n_rem;
        r_key      <= n_key;
        r_walk     <= n_walk;
        r_cd       <= n_cd;
        r_ck       <= n_ck;
        r_res_kind <= n_res_kind;
        r_res_key  <= n_res_key;
        r_out_kind <= n_out_kind;
        r_out_key  <= n_out_key;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem_delta[waddr] <= wdelta;
            r_mem_key[waddr]   <= wkey;
        end
        r_rd_delta <= r_mem_delta[rd_addr];
        r_rd_key   <= r_mem_key[rd_addr];
    end

endmodule

// ----- rtl/delta_list_timer_queue_top.sv -----
// insert: the front captures, multiplies and saturates, then the back pops, walks and
// shifts the stored entries, writes the tail and sends the result
// tick: the same front steps, then in the back pop, front entry read and the result
// for the first expiration, then one result per further expired key
// throughput is one item per back pass, set by the sequential walk over the list
// reset is synchronous, active low: list empty, ticks_per_second 1000, no clearing pass
module delta_list_timer_queue_top #(
    parameter int DEPTH    = dltq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = dltq_pkg::KEY_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_func,
    input  logic [dltq_pkg::DELAY_W-1:0] i_delay_seconds,
    input  logic [dltq_pkg::OKEY_W-1:0]  i_entry_key,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_out_kind,
    output logic [dltq_pkg::OKEY_W-1:0]  o_out_key,
    output logic                         o_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dltq_pkg::PADDR_W-1:0] paddr,
    input  logic [dltq_pkg::PDATA_W-1:0] pwdata,
    output logic [dltq_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    logic           push, q_full, q_empty, q_pop;
    dltq_pkg::t_cmd push_cmd, q_cmd;

    dltq_front #(
        .KEY_BITS(KEY_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_delay_seconds(i_delay_seconds),
        .i_entry_key    (i_entry_key),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_push         (push),
        .o_cmd          (push_cmd),
        .i_q_full       (q_full)
    );

    dltq_cmd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_cmd  (q_cmd)
    );

    dltq_back #(
        .DEPTH   (DEPTH),
        .KEY_BITS(KEY_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_kind (o_out_kind),
        .o_out_key  (o_out_key),
        .o_last     (o_last)
    );

endmodule

// ----- rtl/dltq_checker.sv -----
`include "assert_macros.svh"

module dltq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_out_kind,
    input logic [15:0] o_out_key,
    input logic        o_last,
    input logic        pready
);

    logic        out_held;
    logic [18:0] out_word;
    logic        is_expiry;
    logic        kind_ok;

    assign out_held  = o_out_valid && i_out_stall;
    assign out_word  = {o_out_kind, o_out_key, o_last};
    assign is_expiry = (o_out_kind == dltq_pkg::KIND_EXPIRED);
    assign kind_ok   = o_out_kind inside {dltq_pkg::KIND_ACK, dltq_pkg::KIND_FULL,
                                          dltq_pkg::KIND_EXPIRED};

    // a held result keeps its payload
    `DLTQ_ASSERT(a_out_hold, i_clk, i_rst_n, out_held |=> o_out_valid && $stable(out_word))

    // insert answers are always a single, final result
    `DLTQ_ASSERT(a_insert_last, i_clk, i_rst_n, o_out_valid && !is_expiry |-> o_last)

    // only the three result codes ever leave the block
    `DLTQ_ASSERT(a_kind_code, i_clk, i_rst_n, o_out_valid |-> kind_ok)

    // reset drops any pending result
    `DLTQ_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_out_valid)

    `DLTQ_ASSERT_ALWAYS(a_pready, i_clk, pready)

endmodule

bind delta_list_timer_queue_top dltq_checker u_dltq_checker (.*);

// ----- verif/delta_list_timer_queue_top_tb.sv -----
module delta_list_timer_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = dltq_pkg::DEPTH_DEF;
    localparam int DELTA_W     = dltq_pkg::DELTA_W;
    localparam int DELAY_W     = dltq_pkg::DELAY_W;
    localparam int TPS_W       = dltq_pkg::TPS_W;
    localparam int OKEY_W      = dltq_pkg::OKEY_W;
    localparam int PADDR_W     = dltq_pkg::PADDR_W;
    localparam int PDATA_W     = dltq_pkg::PDATA_W;
    localparam int MAX_RESULTS = dltq_pkg::MAX_RESULTS;
    localparam logic [PADDR_W-1:0] TPS_ADDR = {dltq_pkg::REG_TPS, 2'b00};

    typedef struct {
        logic [1:0]        kind;
        logic [OKEY_W-1:0] key;
        logic              last;
    } t_timer_event;

    // mirror of the delta list; works out the events each request causes
    class expiry_tracker;
        logic [DELTA_W-1:0] delta_q[LIST_DEPTH];
        logic [OKEY_W-1:0]  key_q[LIST_DEPTH];
        int unsigned        count;
        logic [TPS_W-1:0]   rate;
        t_timer_event       due_events[$];
        int                 mismatches;

        function new();
            count = 0;
            rate = dltq_pkg::TPS_RESET;
            mismatches = 0;
        endfunction

        function logic [DELTA_W-1:0] to_ticks(logic [DELAY_W-1:0] secs);
            logic [63:0] prod;
            if (secs[DELAY_W-1]) return dltq_pkg::MAX_DELTA;
            prod = 64'(secs[DELAY_W-2:0]) * 64'(rate);
            if (prod > 64'(dltq_pkg::MAX_DELTA)) return dltq_pkg::MAX_DELTA;
            return prod[DELTA_W-1:0];
        endfunction

        function void note_request(logic func, logic [DELAY_W-1:0] secs,
                                   logic [OKEY_W-1:0] key);
            t_timer_event       ev;
            logic [DELTA_W-1:0] rem;
            int unsigned        pos;
            int                 fired;
            if (func == dltq_pkg::FUNC_INSERT) begin
                ev.key = key;
                ev.last = 1'b1;
                if (count >= LIST_DEPTH) begin
                    ev.kind = dltq_pkg::KIND_FULL;
                    due_events.push_back(ev);
                    return;
                end
                rem = to_ticks(secs);
                pos = 0;
                while (pos < count && delta_q[pos] < rem) begin
                    rem -= delta_q[pos];
                    pos++;
                end
                if (pos < count) delta_q[pos] -= rem;
                for (int j = count; j > pos; j--) begin
                    delta_q[j] = delta_q[j-1];
                    key_q[j] = key_q[j-1];
                end
                delta_q[pos] = rem;
                key_q[pos] = key;
                count++;
                ev.kind = dltq_pkg::KIND_ACK;
                due_events.push_back(ev);
            end else begin
                fired = 0;
                if (count == 0) return;
                if (delta_q[0] > 0) delta_q[0]--;
                while (count > 0 && delta_q[0] == 0 && fired < MAX_RESULTS) begin
                    ev.kind = dltq_pkg::KIND_EXPIRED;
                    ev.key = key_q[0];
                    ev.last = 1'b0;
                    due_events.push_back(ev);
                    fired++;
                    for (int j = 1; j < count; j++) begin
                        delta_q[j-1] = delta_q[j];
                        key_q[j-1] = key_q[j];
                    end
                    count--;
                end
                if (fired > 0) begin
                    ev = due_events.pop_back();
                    ev.last = 1'b1;
                    due_events.push_back(ev);
                end
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [OKEY_W-1:0] key, logic last);
            t_timer_event ev;
            if (due_events.size() == 0) begin
                $error("unexpected result: out_kind %0d out_key %h last %0b",
                       kind, key, last);
                mismatches++;
                return;
            end
            ev = due_events[0];
            due_events.delete(0);
            if (kind !== ev.kind) begin
                $error("out_kind expected %0d got %0d", ev.kind, kind);
                mismatches++;
            end
            if (key !== ev.key) begin
                $error("out_key expected %h got %h", ev.key, key);
                mismatches++;
            end
            if (last !== ev.last) begin
                $error("last expected %0b got %0b", ev.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_func = dltq_pkg::FUNC_INSERT;
    logic [DELAY_W-1:0]  i_delay_seconds = '0;
    logic [OKEY_W-1:0]   i_entry_key = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [1:0]          o_out_kind;
    logic [OKEY_W-1:0]   o_out_key;
    logic                o_last;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    bit                  calm = 1'b0;
    int                  stall_left = 0;
    expiry_tracker       trk = new();

    delta_list_timer_queue_top #(
        .DEPTH    (LIST_DEPTH),
        .KEY_BITS (dltq_pkg::KEY_BITS_DEF)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_delay_seconds (i_delay_seconds),
        .i_entry_key     (i_entry_key),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_kind      (o_out_kind),
        .o_out_key       (o_out_key),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_out_stall = 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_stall = 1'b1;
            stall_left--;
        end else begin
            i_out_stall = 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            trk.check_result(o_out_kind, o_out_key, o_last);
    end

    // called and returns at a falling edge
    task automatic send_request(logic func, logic [DELAY_W-1:0] secs, logic [OKEY_W-1:0] key);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_func = func;
        i_delay_seconds = secs;
        i_entry_key = key;
        do @(posedge i_clk); while (o_in_stall);
        trk.note_request(func, secs, key);
        @(negedge i_clk);
    endtask

    // block idle: nothing pending, and time for a tick that emits nothing
    task automatic wait_quiet();
        i_in_valid = 1'b0;
        while (trk.due_events.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_access(bit wr, logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = TPS_ADDR;
        pwdata = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_rate(logic [TPS_W-1:0] rate);
        logic [PDATA_W-1:0] rd;
        wait_quiet();
        apb_access(1'b1, PDATA_W'(rate), rd);
        trk.rate = rate;
        apb_access(1'b0, '0, rd);
        if (rd[TPS_W-1:0] !== rate) begin
            $error("ticks_per_second expected %0d got %0d", rate, rd[TPS_W-1:0]);
            trk.mismatches++;
        end
    endtask

    initial begin
        logic [TPS_W-1:0]   phase_rate[6];
        logic [DELAY_W-1:0] secs;
        int                 pick;
        int                 far_left;
        phase_rate = '{20'd1, 20'd0, 20'd1000000, 20'hFFFFF, 20'd7, 20'd1};
        far_left = 3;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty list, zero delay, saturation
        send_request(dltq_pkg::FUNC_TICK, '0, '0);
        send_request(dltq_pkg::FUNC_INSERT, '0, 16'h0000);
        send_request(dltq_pkg::FUNC_TICK, '1, '1);
        set_rate(dltq_pkg::TPS_RESET);
        send_request(dltq_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
        send_request(dltq_pkg::FUNC_INSERT, 32'h8000_0000, 16'h1234);
        send_request(dltq_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 16'h8000);

        // equal remainders go before the stored entry
        set_rate(20'd1);
        send_request(dltq_pkg::FUNC_INSERT, 32'd2, 16'hA000);
        send_request(dltq_pkg::FUNC_INSERT, 32'd1, 16'hB000);
        send_request(dltq_pkg::FUNC_INSERT, 32'd2, 16'hC000);
        send_request(dltq_pkg::FUNC_TICK, '0, '0);
        send_request(dltq_pkg::FUNC_TICK, '0, '0);

        // fill the list, overflow it, then expire everything due at once
        for (int i = 0; i < LIST_DEPTH - 3; i++)
            send_request(dltq_pkg::FUNC_INSERT, '0, OKEY_W'(16'h0100 + i));
        send_request(dltq_pkg::FUNC_INSERT, 32'd5, 16'h5A5A);
        send_request(dltq_pkg::FUNC_TICK, '0, '0);

        foreach (phase_rate[p]) begin
            set_rate(phase_rate[p]);
            calm = (p == 3);
            for (int n = 0; n < 34; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    send_request(dltq_pkg::FUNC_TICK, $urandom, OKEY_W'($urandom));
                end else begin
                    // far entries never expire, so only a few are spent
                    if (pick < 49 && far_left > 0) begin
                        secs = $urandom;
                        far_left--;
                    end else if (trk.rate == 0) begin
                        secs = $urandom & 32'h7FFF_FFFF;
                    end else begin
                        secs = $urandom_range(0, 40 / trk.rate);
                    end
                    send_request(dltq_pkg::FUNC_INSERT, secs, OKEY_W'($urandom));
                end
            end
        end
        calm = 1'b0;

        wait_quiet();
        if (trk.mismatches == 0 && trk.due_events.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule
